// File: rtl/mme_pkg.sv
// Shared types and constants for the matrix multiply element engine.
// Holds the request/result transaction structs, command and register codes.
// No dependencies.
package mme_pkg;

	// Field widths fixed by the transaction format
	localparam int CMD_W     = 2;
	localparam int IDX_W     = 5;
	localparam int VAL_W     = 16;
	localparam int SUM_BITS  = 40;
	localparam int REG_W     = 6;
	localparam int CFG_IDX_W = 2;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_A_ROWS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_B_COLS    = 2'd2;

	localparam logic [REG_W-1:0] REG_RESET = 6'd32;

	typedef struct packed {
		logic [CMD_W-1:0]        cmd;
		logic [IDX_W-1:0]        row_index;
		logic [IDX_W-1:0]        col_index;
		logic signed [VAL_W-1:0] element_value;
	} request_t;

	typedef struct packed {
		logic signed [SUM_BITS-1:0] product_sum;
		logic                       index_error;
	} result_t;

	// Clamp a size register to the physical dimension
	function automatic logic [REG_W-1:0] eff_size(input logic [REG_W-1:0] size, input int lim);
		logic [REG_W-1:0] r;
		r = size;
		if (int'(size) > lim)
			r = REG_W'(lim);
		return r;
	endfunction

endpackage

// File: rtl/mme_store.sv
// Operand store: one write port, one registered read port.
// Used for both the A and the B matrix. Depends on nothing.
module mme_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 16
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_data_s1;

	// Write one entry
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	// Read every cycle, data registered
	always_ff @(posedge clk) begin
		rd_data_s1 <= mem[rd_addr];
	end

	assign rd_data = rd_data_s1;

endmodule

// File: rtl/mme_mac.sv
// Shared multiply-accumulate unit: registered product, saturating 40-bit sum.
// Depends on mme_pkg for the sum width.
module mme_mac #(
	parameter int OPERAND_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               clear,
	input  logic                               op_valid,
	input  logic signed [OPERAND_BITS-1:0]     op_a,
	input  logic signed [OPERAND_BITS-1:0]     op_b,
	output logic signed [mme_pkg::SUM_BITS-1:0] acc,
	output logic                               busy
);

	localparam int PW = 2 * OPERAND_BITS;
	localparam int SW = (PW > mme_pkg::SUM_BITS ? PW : mme_pkg::SUM_BITS) + 1;
	localparam logic signed [SW-1:0] SAT_HI =
		{{(SW - mme_pkg::SUM_BITS + 1){1'b0}}, {(mme_pkg::SUM_BITS - 1){1'b1}}};
	localparam logic signed [SW-1:0] SAT_LO =
		{{(SW - mme_pkg::SUM_BITS + 1){1'b1}}, {(mme_pkg::SUM_BITS - 1){1'b0}}};

	logic signed [PW-1:0]                prod_s2;
	logic                                valid_s2;
	logic signed [mme_pkg::SUM_BITS-1:0] acc_q;
	logic signed [SW-1:0]                sum;
	logic signed [mme_pkg::SUM_BITS-1:0] sum_sat;

	// Multiply stage
	always_ff @(posedge clk) begin
		prod_s2 <= op_a * op_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= op_valid && !clear;
		end
	end

	// Add and clamp to the 40-bit signed range
	always_comb begin
		sum = SW'(acc_q) + SW'(prod_s2);
		if (sum > SAT_HI)
			sum_sat = SAT_HI[mme_pkg::SUM_BITS-1:0];
		else if (sum < SAT_LO)
			sum_sat = SAT_LO[mme_pkg::SUM_BITS-1:0];
		else
			sum_sat = sum[mme_pkg::SUM_BITS-1:0];
	end

	// Accumulate, restart from zero on clear
	always_ff @(posedge clk) begin
		if (clear)
			acc_q <= '0;
		else if (valid_s2)
			acc_q <= sum_sat;
	end

	assign acc  = acc_q;
	assign busy = valid_s2;

endmodule

// File: rtl/matrix_multiply_element.sv
// Top level of the matrix multiply element engine: config registers,
// sequencer, A/B operand stores and the shared MAC. Uses mme_pkg,
// mme_store and mme_mac.
//
//  channel   signals                            width   direction
//  request   request_valid/request_stall        28      into block
//  result    result_valid/result_stall          41      out of block
//  config    cfg_valid/cfg_ready, index, data   2 + 6   into block
//
// Loads and ignored commands do not stall the request channel.
// A compute stalls the request channel until its result is loaded into the output
// register; the single MAC eats one A/B pair a cycle.
// Out-of-range or zero-length computes skip the MAC and go straight to done.
// Reset clears control and sets the size registers to 32; store contents stay undefined.
// A finished result waits in the output register while result_stall is high;
// loads are still taken meanwhile, a following compute holds at its end.
module matrix_multiply_element #(
	parameter int MAX_DIM      = 32,
	parameter int OPERAND_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             request_valid,
	output logic                             request_stall,
	input  mme_pkg::request_t                request,
	output logic                             result_valid,
	input  logic                             result_stall,
	output mme_pkg::result_t                 result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [mme_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mme_pkg::REG_W-1:0]        cfg_data
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int KW    = $clog2(MAX_DIM);
	localparam int CW    = (KW > mme_pkg::REG_W ? KW : mme_pkg::REG_W) + 1;
	localparam logic [AW-1:0] DIM_A = AW'(MAX_DIM);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]                       state_q;
	logic [mme_pkg::REG_W-1:0]        a_rows_q, inner_dim_q, b_cols_q;
	logic [mme_pkg::REG_W-1:0]        nr, nk, nc;
	logic [mme_pkg::IDX_W-1:0]        row_q, col_q;
	logic [KW-1:0]                    k_q;
	logic                             err_q;
	logic                             rd_v_s1;
	logic                             req_acc;
	logic                             is_compute;
	logic                             in_range;
	logic                             k_last;
	logic                             slot_free;
	logic                             res_load;
	logic                             mac_clear;
	logic                             mac_busy;
	logic                             wr_a_en, wr_b_en;
	logic [AW-1:0]                    wr_addr, a_rd_addr, b_rd_addr;
	logic [OPERAND_BITS+mme_pkg::VAL_W-1:0] val_ext;
	logic [OPERAND_BITS-1:0]          wr_data;
	logic [OPERAND_BITS-1:0]          a_rd_data, b_rd_data;
	logic signed [mme_pkg::SUM_BITS-1:0] acc;
	mme_pkg::result_t                 result_q;
	logic                             result_valid_q;

	// Sizes in use, clamped to the physical dimension
	assign nr = mme_pkg::eff_size(a_rows_q, MAX_DIM);
	assign nk = mme_pkg::eff_size(inner_dim_q, MAX_DIM);
	assign nc = mme_pkg::eff_size(b_cols_q, MAX_DIM);

	// Configuration writes, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q    <= mme_pkg::REG_RESET;
			inner_dim_q <= mme_pkg::REG_RESET;
			b_cols_q    <= mme_pkg::REG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mme_pkg::REG_A_ROWS:    a_rows_q    <= cfg_data;
				mme_pkg::REG_INNER_DIM: inner_dim_q <= cfg_data;
				mme_pkg::REG_B_COLS:    b_cols_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Request handshake and decode
	assign request_stall = (state_q != ST_IDLE);
	assign req_acc       = request_valid && !request_stall;
	assign is_compute    = (request.cmd == mme_pkg::CMD_COMPUTE);
	assign in_range      = ({1'b0, request.row_index} < nr) && ({1'b0, request.col_index} < nc);
	assign mac_clear     = req_acc && is_compute;

	// Load path: drop out-of-range elements
	assign wr_a_en = req_acc && (request.cmd == mme_pkg::CMD_LOAD_A)
		&& ({1'b0, request.row_index} < nr) && ({1'b0, request.col_index} < nk);
	assign wr_b_en = req_acc && (request.cmd == mme_pkg::CMD_LOAD_B)
		&& ({1'b0, request.row_index} < nk) && ({1'b0, request.col_index} < nc);
	assign wr_addr = AW'(request.row_index) * DIM_A + AW'(request.col_index);
	assign val_ext = {{OPERAND_BITS{1'b0}}, request.element_value};
	assign wr_data = val_ext[OPERAND_BITS-1:0];

	// Walk row of A and column of B
	assign a_rd_addr = AW'(row_q) * DIM_A + AW'(k_q);
	assign b_rd_addr = AW'(k_q) * DIM_A + AW'(col_q);
	assign k_last    = ((CW'(k_q) + CW'(1)) == CW'(nk));
	assign slot_free = !result_valid_q || !result_stall;
	assign res_load  = (state_q == ST_DONE) && slot_free;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			rd_v_s1 <= 1'b0;
			err_q   <= 1'b0;
		end else begin
			rd_v_s1 <= (state_q == ST_RUN);
			unique case (state_q)
				ST_IDLE: begin
					if (req_acc && is_compute) begin
						k_q   <= '0;
						err_q <= !in_range;
						if (in_range && (nk != '0))
							state_q <= ST_RUN;
						else
							state_q <= ST_DONE;
					end
				end
				ST_RUN: begin
					k_q <= k_q + KW'(1);
					if (k_last)
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (!rd_v_s1 && !mac_busy)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (slot_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the addressed result element
	always_ff @(posedge clk) begin
		if (req_acc && is_compute) begin
			row_q <= request.row_index;
			col_q <= request.col_index;
		end
	end

	mme_store #(.DEPTH(DEPTH), .AW(AW), .DW(OPERAND_BITS)) u_store_a (
		.clk     (clk),
		.wr_en   (wr_a_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (a_rd_addr),
		.rd_data (a_rd_data)
	);

	mme_store #(.DEPTH(DEPTH), .AW(AW), .DW(OPERAND_BITS)) u_store_b (
		.clk     (clk),
		.wr_en   (wr_b_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (b_rd_addr),
		.rd_data (b_rd_data)
	);

	mme_mac #(.OPERAND_BITS(OPERAND_BITS)) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (mac_clear),
		.op_valid (rd_v_s1),
		.op_a     ($signed(a_rd_data)),
		.op_b     ($signed(b_rd_data)),
		.acc      (acc),
		.busy     (mac_busy)
	);

	// Output register, advance when the consumer takes the transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (res_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			result_q.product_sum <= acc;
			result_q.index_error <= err_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Checks
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.index_error && (result.product_sum != '0)))
		else $error("index error result with nonzero sum");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!rd_v_s1 && !mac_busy))
		else $error("MAC pipeline active while idle");

	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (CW'(k_q) < CW'(nk)))
		else $error("inner index beyond inner dimension");

	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == ST_DONE))
		else $error("result raised outside of completion");

endmodule
